@@ sv/imt_pkg.sv @@
// Package: shared types, constants and codes for the in-place transpose block
`timescale 1ns / 1ps
package imt_pkg;
  localparam int MAX_ELEMS_DEF  = 1024;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int DIM_W   = 11;
  localparam int IDX_W   = 10;
  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int CFG_A_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 2'd0,
    OP_TRANSPOSE = 2'd1,
    OP_READ      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_SIZE  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam logic [CFG_A_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_COLS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SQ_RDA,
    S_SQ_RDB,
    S_SQ_WA,
    S_SQ_WB,
    S_RC_START,
    S_RC_SCAN,
    S_RC_RD0,
    S_RC_RDF,
    S_RC_WR,
    S_RC_DIV,
    S_RESP
  } state_t;
endpackage

@@ sv/imt_if.sv @@
// Interfaces: valid/ready item channels and configuration write channel
`timescale 1ns / 1ps
interface imt_in_if;
  logic                      valid;
  logic                      ready;
  logic [imt_pkg::OP_W-1:0]  operation;
  logic [imt_pkg::IDX_W-1:0] index;
  logic [imt_pkg::DATA_W-1:0] wdata;
  modport source (output valid, operation, index, wdata, input ready);
  modport sink   (input valid, operation, index, wdata, output ready);
endinterface

interface imt_out_if;
  logic                       valid;
  logic                       ready;
  logic [imt_pkg::DATA_W-1:0] rdata;
  logic [imt_pkg::ST_W-1:0]   status;
  modport source (output valid, rdata, status, input ready);
  modport sink   (input valid, rdata, status, output ready);
endinterface

interface imt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [imt_pkg::CFG_A_W-1:0] addr;
  logic [imt_pkg::DIM_W-1:0]   data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ sv/inplace_matrix_transpose.sv @@
// Top level: element store with in-place transpose by cycle following
//
//  channel | dir | beat payload                  | handshake
//  --------+-----+-------------------------------+-------------------
//  in_     | in  | operation, index, wdata       | in_valid/in_ready
//  out_    | out | rdata, status                 | out_valid/out_ready
//  cfg_    | in  | addr (0 rows, 1 cols), data   | cfg_valid/cfg_ready
//
// Write: stored on acceptance, then the result beat. Read: registered read, then the result beat.
// Square transpose: two reads and two writes per mirrored pair.
// Rectangular: each start index s is checked by walking its cycle, one
// divide per step; a fresh cycle is then moved, one divide per element.
// Reset (rst_n, synchronous) clears control only; store is undefined.
// in_ready is low from acceptance until the result beat is taken.
`timescale 1ns / 1ps
module inplace_matrix_transpose #(
  parameter int MAX_ELEMS  = imt_pkg::MAX_ELEMS_DEF,
  parameter int ELEM_WIDTH = imt_pkg::ELEM_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  imt_in_if.sink    in_ch,
  imt_out_if.source out_ch,
  imt_cfg_if.sink   cfg_ch
);
  localparam int AW = $clog2(MAX_ELEMS);
  localparam int PW = 2 * imt_pkg::DIM_W;   // product / perm width
  localparam int DW = PW;                   // divider width

  imt_pkg::state_t state_r, state_nxt;

  logic [imt_pkg::DIM_W-1:0] rows_r, cols_r;
  logic [PW-1:0] total;
  assign total = PW'(rows_r) * PW'(cols_r);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      cols_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        imt_pkg::REG_ROWS: rows_r <= cfg_ch.data;
        imt_pkg::REG_COLS: cols_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // store port
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [ELEM_WIDTH-1:0] ram_wd, ram_rd;

  imt_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_ELEMS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ram_wd),
    .raddr(raddr), .rdata(ram_rd)
  );

  // shared divider
  logic          div_start, div_done;
  logic [DW-1:0] div_a, div_b, div_q, div_r;

  imt_divmod #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quot(div_q), .rem(div_r)
  );

  // working registers
  logic [imt_pkg::DATA_W-1:0] rdata_r, rdata_nxt;
  imt_pkg::status_t status_r, status_nxt;
  logic [PW-1:0] i_r, i_nxt, j_r, j_nxt;       // square loop indices
  logic [PW-1:0] s_r, s_nxt, fwd_r, fwd_nxt, bwd_r, bwd_nxt, at_r, at_nxt;
  logic [PW-1:0] last_r, last_nxt;
  logic [2:0]    ph_r, ph_nxt;                 // sub-phase in rect scan/move and square swap
  logic [ELEM_WIDTH-1:0] tmp_r, tmp_nxt, hold_r, hold_nxt;

  // rect phases
  localparam logic [2:0] PH_F0 = 3'd0;  // fwd = perm(s, m, n) (div by n)
  localparam logic [2:0] PH_B0 = 3'd1;  // bwd = perm(s, n, m) (div by m)
  localparam logic [2:0] PH_FW = 3'd2;  // walk fwd
  localparam logic [2:0] PH_BW = 3'd3;  // walk bwd

  logic [PW-1:0] perm_fwd, perm_bwd;
  assign perm_fwd = PW'(div_r * PW'(rows_r)) + div_q;  // divided by cols
  assign perm_bwd = PW'(div_r * PW'(cols_r)) + div_q;  // divided by rows

  assign in_ch.ready  = (state_r == imt_pkg::S_IDLE);
  assign out_ch.valid = (state_r == imt_pkg::S_RESP);
  assign out_ch.rdata = rdata_r;
  assign out_ch.status = status_r;

  always_comb begin
    state_nxt  = state_r;
    rdata_nxt  = rdata_r;
    status_nxt = status_r;
    i_nxt = i_r; j_nxt = j_r; s_nxt = s_r; fwd_nxt = fwd_r; bwd_nxt = bwd_r;
    at_nxt = at_r; last_nxt = last_r; ph_nxt = ph_r;
    tmp_nxt = tmp_r; hold_nxt = hold_r;
    we = 1'b0; waddr = '0; ram_wd = '0; raddr = '0;
    div_start = 1'b0; div_a = '0; div_b = '0;
    unique case (state_r)
      imt_pkg::S_IDLE: begin
        raddr = AW'(in_ch.index);
        if (in_ch.valid) begin
          rdata_nxt  = '0;
          status_nxt = imt_pkg::ST_OK;
          unique case (imt_pkg::op_t'(in_ch.operation))
            imt_pkg::OP_WRITE, imt_pkg::OP_READ: begin
              if (PW'(in_ch.index) >= total ||
                  32'(in_ch.index) >= 32'(MAX_ELEMS)) begin
                status_nxt = imt_pkg::ST_INDEX;
                state_nxt  = imt_pkg::S_RESP;
              end else if (in_ch.operation == imt_pkg::OP_WRITE) begin
                we = 1'b1;
                waddr = AW'(in_ch.index);
                ram_wd = ELEM_WIDTH'(in_ch.wdata);
                state_nxt = imt_pkg::S_RESP;
              end else begin
                state_nxt = imt_pkg::S_RD_WAIT;
              end
            end
            imt_pkg::OP_TRANSPOSE: begin
              if (rows_r <= 1 || cols_r <= 1) begin
                state_nxt = imt_pkg::S_RESP;
              end else if (total > PW'(MAX_ELEMS)) begin
                status_nxt = imt_pkg::ST_SIZE;
                state_nxt  = imt_pkg::S_RESP;
              end else if (rows_r == cols_r) begin
                i_nxt = '0;
                j_nxt = PW'(1);
                ph_nxt = PH_F0;
                state_nxt = imt_pkg::S_SQ_RDA;
              end else begin
                last_nxt = total - 1'b1;
                s_nxt = PW'(1);
                state_nxt = imt_pkg::S_RC_START;
              end
            end
            default: state_nxt = imt_pkg::S_RESP;
          endcase
        end
      end
      imt_pkg::S_RD_WAIT: begin
        rdata_nxt = imt_pkg::DATA_W'(ram_rd);
        state_nxt = imt_pkg::S_RESP;
      end
      // square: swap (i*n+j) and (j*n+i); i*n+j kept in at, j*n+i in fwd
      imt_pkg::S_SQ_RDA: begin
        at_nxt  = PW'(i_r * PW'(rows_r)) + j_r;
        state_nxt = imt_pkg::S_SQ_RDB;
      end
      imt_pkg::S_SQ_RDB: begin
        raddr = AW'(at_r);
        fwd_nxt = PW'(j_r * PW'(rows_r)) + i_r;
        state_nxt = imt_pkg::S_SQ_WA;
      end
      imt_pkg::S_SQ_WA: begin
        tmp_nxt = ram_rd;
        raddr = AW'(fwd_r);
        state_nxt = imt_pkg::S_SQ_WB;
      end
      imt_pkg::S_SQ_WB: begin
        if (ph_r == PH_F0) begin
          hold_nxt = ram_rd;
          ph_nxt = PH_B0;
        end else begin
          we = 1'b1; waddr = AW'(at_r); ram_wd = hold_r;
          ph_nxt = PH_F0;
        end
        if (ph_r == PH_B0) begin
          // second write done next: write A value to B position via fwd
          state_nxt = imt_pkg::S_RC_WR;
          at_nxt = fwd_r;
        end
      end
      imt_pkg::S_RC_WR: begin
        we = 1'b1; waddr = AW'(at_r); ram_wd = tmp_r;
        if (rows_r == cols_r) begin
          if (j_r + 1'b1 < PW'(rows_r)) begin
            j_nxt = j_r + 1'b1;
            state_nxt = imt_pkg::S_SQ_RDA;
          end else if (i_r + PW'(2) < PW'(rows_r)) begin
            i_nxt = i_r + 1'b1;
            j_nxt = i_r + PW'(2);
            state_nxt = imt_pkg::S_SQ_RDA;
          end else begin
            state_nxt = imt_pkg::S_RESP;
          end
        end else begin
          // rect: closing write of the cycle
          s_nxt = s_r + 1'b1;
          state_nxt = imt_pkg::S_RC_START;
        end
      end
      // rectangular: scan start s for a fresh cycle with min index s
      imt_pkg::S_RC_START: begin
        if (s_r >= last_r) begin
          state_nxt = imt_pkg::S_RESP;
        end else begin
          div_start = 1'b1; div_a = s_r; div_b = PW'(cols_r);
          ph_nxt = PH_F0;
          state_nxt = imt_pkg::S_RC_SCAN;
        end
      end
      imt_pkg::S_RC_SCAN: begin
        if (div_done) begin
          priority case (ph_r)
            PH_F0: begin
              fwd_nxt = perm_fwd;
              if (perm_fwd <= s_r) begin
                s_nxt = s_r + 1'b1;
                state_nxt = imt_pkg::S_RC_START;
              end else begin
                div_start = 1'b1; div_a = s_r; div_b = PW'(rows_r);
                ph_nxt = PH_B0;
              end
            end
            PH_B0: begin
              bwd_nxt = perm_bwd;
              if (perm_bwd <= s_r) begin
                s_nxt = s_r + 1'b1;
                state_nxt = imt_pkg::S_RC_START;
              end else if (perm_bwd == fwd_r) begin
                state_nxt = imt_pkg::S_RC_RD0;
              end else begin
                div_start = 1'b1; div_a = fwd_r; div_b = PW'(cols_r);
                ph_nxt = PH_FW;
              end
            end
            PH_FW: begin
              fwd_nxt = perm_fwd;
              if (perm_fwd < s_r) begin
                s_nxt = s_r + 1'b1;
                state_nxt = imt_pkg::S_RC_START;
              end else begin
                div_start = 1'b1; div_a = bwd_r; div_b = PW'(rows_r);
                ph_nxt = PH_BW;
              end
            end
            default: begin
              bwd_nxt = perm_bwd;
              if (perm_bwd < s_r) begin
                s_nxt = s_r + 1'b1;
                state_nxt = imt_pkg::S_RC_START;
              end else if (perm_bwd == fwd_r) begin
                state_nxt = imt_pkg::S_RC_RD0;
              end else begin
                div_start = 1'b1; div_a = fwd_r; div_b = PW'(cols_r);
                ph_nxt = PH_FW;
              end
            end
          endcase
        end
      end
      // move cycle: tmp = store[s]; store[at] = store[perm(at,n,m)]
      imt_pkg::S_RC_RD0: begin
        raddr = AW'(s_r);
        at_nxt = s_r;
        div_start = 1'b1; div_a = s_r; div_b = PW'(rows_r);
        state_nxt = imt_pkg::S_RC_DIV;
        ph_nxt = PH_F0;
      end
      imt_pkg::S_RC_DIV: begin
        if (ph_r == PH_F0) begin
          tmp_nxt = ram_rd;
          ph_nxt = PH_B0;
        end
        if (div_done) begin
          if (perm_bwd == s_r) begin
            state_nxt = imt_pkg::S_RC_WR;
          end else begin
            fwd_nxt = perm_bwd;
            state_nxt = imt_pkg::S_RC_RDF;
          end
        end
      end
      imt_pkg::S_RC_RDF: begin
        raddr = AW'(fwd_r);
        if (ph_r == PH_B0) begin
          ph_nxt = PH_FW;
        end else begin
          we = 1'b1; waddr = AW'(at_r); ram_wd = ram_rd;
          at_nxt = fwd_r;
          div_start = 1'b1; div_a = fwd_r; div_b = PW'(rows_r);
          ph_nxt = PH_B0;
          state_nxt = imt_pkg::S_RC_DIV;
        end
      end
      imt_pkg::S_RESP: begin
        if (out_ch.ready) begin
          state_nxt = imt_pkg::S_IDLE;
        end
      end
      default: state_nxt = imt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imt_pkg::S_IDLE;
      ph_r    <= PH_F0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
    rdata_r <= rdata_nxt; status_r <= status_nxt;
    i_r <= i_nxt; j_r <= j_nxt; s_r <= s_nxt; fwd_r <= fwd_nxt;
    bwd_r <= bwd_nxt; at_r <= at_nxt; last_r <= last_nxt;
    tmp_r <= tmp_nxt; hold_r <= hold_nxt;
  end
endmodule

@@ sv/imt_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module imt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/imt_divmod.sv @@
// Restoring divider: quotient and remainder, one bit per cycle
`timescale 1ns / 1ps
module imt_divmod #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [W:0]    trial;
  logic [W-1:0]  q_step, r_step;

  // one restoring step; the result taps this so start cannot disturb it
  always_comb begin
    trial = {r_r, q_r[W-1]} - {1'b0, d_r};
    if (!trial[W]) begin
      r_step = trial[W-1:0];
      q_step = {q_r[W-2:0], 1'b1};
    end else begin
      r_step = {r_r[W-2:0], q_r[W-1]};
      q_step = {q_r[W-2:0], 1'b0};
    end
  end

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt   = r_step;
      q_nxt   = q_step;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1));
  assign quot = q_step;
  assign rem  = r_step;
endmodule
